>>> design/sis_pkg.sv
// Shared types and constants for the sorted insert stack.
package sis_pkg;

   // Number of cells in the chain and bits kept from each tag.
   localparam int DEPTH         = 16;
   localparam int TAG_BITS      = 8;

   // Widths fixed by the item fields.
   localparam int KIND_BITS     = 2;
   localparam int TIME_BITS     = 16;
   localparam int TAG_PORT_BITS = 8;
   localparam int CNT_BITS      = 5;

   // Operation codes carried in the kind field.
   localparam logic [KIND_BITS-1:0] KIND_SORTED_PUSH = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_PLAIN_PUSH  = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_POP         = 2'd2;

   // One stored entry.
   typedef struct packed {
      logic                 valid;
      logic [TIME_BITS-1:0] start_time;
      logic [TAG_BITS-1:0]  tag;
   } entry_type;

   localparam entry_type EMPTY_ENTRY = '{valid: 1'b0, start_time: '0, tag: '0};

   // Operation broadcast to every cell; the enables are already qualified.
   typedef struct packed {
      logic                 sorted_push;
      logic                 plain_push;
      logic                 pop;
      logic [TIME_BITS-1:0] key;
      logic [TAG_BITS-1:0]  tag;
   } ctrl_type;

endpackage

>>> design/sis_cell.sv
// One cell of the stack: holds an entry and trades it with its neighbors.
module sis_cell (
   input  logic                clock,
   input  logic                reset,
   input  sis_pkg::ctrl_type   ctrl,
   input  sis_pkg::entry_type  upper_entry,
   input  sis_pkg::entry_type  lower_entry,
   input  logic                hit_above,
   output logic                hit_here_or_above,
   output sis_pkg::entry_type  entry
);

   sis_pkg::entry_type entry_ff;
   sis_pkg::entry_type entry_in;
   logic               hit;

   // Mark the insert point: an empty cell or a key not below the new one.
   // A plain push always lands at the top, so every cell counts as a hit.
   always_comb begin
      hit = ctrl.plain_push || !entry_ff.valid || (entry_ff.start_time >= ctrl.key);
   end

   assign hit_here_or_above = hit_above | hit;

   // Shift down below the insert point, load at it, shift up on a pop.
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.sorted_push || ctrl.plain_push) begin
         if (hit_above) begin
            entry_in = upper_entry;
         end else if (hit) begin
            entry_in.valid      = 1'b1;
            entry_in.start_time = ctrl.key;
            entry_in.tag        = ctrl.tag;
         end
      end else if (ctrl.pop) begin
         entry_in = lower_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= sis_pkg::EMPTY_ENTRY;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

>>> design/sorted_insert_stack.sv
// Sorted insert stack: a chain of cells kept in key order from the top.
// Latency: the result of an item is presented in the cycle after it is accepted.
// Throughput: one item per cycle when no result is stalled; every cell compares and shifts
// in the same cycle, and the insert point ripples down the chain of cells within that cycle.
// An item is taken while the previous result is being taken.
// Reset (synchronous, active high) empties all cells and drops any pending result.
module sorted_insert_stack (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [sis_pkg::KIND_BITS-1:0]      req_kind,
   input  logic [sis_pkg::TIME_BITS-1:0]      req_start_time,
   input  logic [sis_pkg::TAG_PORT_BITS-1:0]  req_payload_tag,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_top_valid,
   output logic [sis_pkg::TIME_BITS-1:0]      rsp_top_time,
   output logic [sis_pkg::TAG_PORT_BITS-1:0]  rsp_top_tag,
   output logic [sis_pkg::CNT_BITS-1:0]       rsp_entry_count,
   output logic                               rsp_overflow
);

   sis_pkg::ctrl_type                ctrl;
   sis_pkg::entry_type               cell_entry [sis_pkg::DEPTH];
   sis_pkg::entry_type               upper_in   [sis_pkg::DEPTH];
   sis_pkg::entry_type               lower_in   [sis_pkg::DEPTH];
   logic [sis_pkg::DEPTH:0]          hit_chain;
   logic                             accept;
   logic                             is_push;
   logic                             full;
   logic                             empty;
   logic                             rsp_valid_ff;
   logic                             rsp_valid_in;
   logic                             overflow_ff;
   logic                             overflow_in;
   logic [sis_pkg::CNT_BITS-1:0]     count_ff;
   logic [sis_pkg::CNT_BITS-1:0]     count_in;

   // Take an item unless a result is waiting and stalled.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign full    = cell_entry[sis_pkg::DEPTH-1].valid;
   assign empty   = !cell_entry[0].valid;
   assign is_push = (req_kind == sis_pkg::KIND_SORTED_PUSH) ||
                    (req_kind == sis_pkg::KIND_PLAIN_PUSH);

   // Decode the item into qualified cell operations.
   always_comb begin
      ctrl.sorted_push = accept && !full && (req_kind == sis_pkg::KIND_SORTED_PUSH);
      ctrl.plain_push  = accept && !full && (req_kind == sis_pkg::KIND_PLAIN_PUSH);
      ctrl.pop         = accept && !empty && (req_kind == sis_pkg::KIND_POP);
      ctrl.key         = req_start_time;
      ctrl.tag         = sis_pkg::TAG_BITS'(req_payload_tag);
   end

   // Wire each cell to its neighbors; the ends see an empty entry.
   always_comb begin
      for (int i = 0; i < sis_pkg::DEPTH; i++) begin
         upper_in[i] = (i == 0) ? sis_pkg::EMPTY_ENTRY : cell_entry[(i == 0) ? 0 : i-1];
         lower_in[i] = (i == sis_pkg::DEPTH-1) ? sis_pkg::EMPTY_ENTRY
                     : cell_entry[(i == sis_pkg::DEPTH-1) ? i : i+1];
      end
   end

   assign hit_chain[0] = 1'b0;

   for (genvar g = 0; g < sis_pkg::DEPTH; g++) begin : g_cell
      sis_cell u_cell (
         .clock             (clock),
         .reset             (reset),
         .ctrl              (ctrl),
         .upper_entry       (upper_in[g]),
         .lower_entry       (lower_in[g]),
         .hit_above         (hit_chain[g]),
         .hit_here_or_above (hit_chain[g+1]),
         .entry             (cell_entry[g])
      );
   end

   // Track the fill count, the overflow flag and the result valid.
   always_comb begin
      count_in     = count_ff;
      overflow_in  = overflow_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (accept) begin
         rsp_valid_in = 1'b1;
         overflow_in  = is_push && full;
         if (ctrl.sorted_push || ctrl.plain_push) begin
            count_in = count_ff + 1'b1;
         end else if (ctrl.pop) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The top cell holds still while a result waits, so it drives the item.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_top_valid   = cell_entry[0].valid;
   assign rsp_top_time    = cell_entry[0].start_time;
   assign rsp_top_tag     = sis_pkg::TAG_PORT_BITS'(cell_entry[0].tag);
   assign rsp_entry_count = count_ff;
   assign rsp_overflow    = overflow_ff;

endmodule

>>> tb/sv/sorted_insert_stack_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the sorted insert stack: directed table, random items, scoreboard.
module sorted_insert_stack_tb;

   // Kind code that the block treats as no operation.
   localparam logic [sis_pkg::KIND_BITS-1:0] KIND_NOP = 2'd3;
   localparam int N_RANDOM    = 700;
   localparam int IDLE_PCT    = 28;
   localparam int QUIET_FIRST = 300;
   localparam int QUIET_LAST  = 420;

   // One result item as the block reports it.
   typedef struct packed {
      logic                              top_valid;
      logic [sis_pkg::TIME_BITS-1:0]     top_time;
      logic [sis_pkg::TAG_PORT_BITS-1:0] top_tag;
      logic [sis_pkg::CNT_BITS-1:0]      entry_count;
      logic                              overflow;
   } stack_status_type;

   // One row of the directed table; has_exp selects a typed-in expectation.
   typedef struct packed {
      logic [sis_pkg::KIND_BITS-1:0]     kind;
      logic [sis_pkg::TIME_BITS-1:0]     key;
      logic [sis_pkg::TAG_PORT_BITS-1:0] tag;
      logic                              has_exp;
      stack_status_type                  exp;
   } directed_row_type;

   localparam int N_DIRECTED = 23;
   localparam directed_row_type DIRECTED [N_DIRECTED] = '{
      // pop and no-op on the empty stack
      '{sis_pkg::KIND_POP,         16'h0000, 8'h00, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0, 1'b0}},
      '{KIND_NOP,                  16'hFFFF, 8'hFF, 1'b1, '{1'b0, 16'h0000, 8'h00, 5'd0, 1'b0}},
      // first entry, walk to the bottom, new top, equal key
      '{sis_pkg::KIND_SORTED_PUSH, 16'h1234, 8'hAB, 1'b1, '{1'b1, 16'h1234, 8'hAB, 5'd1, 1'b0}},
      '{sis_pkg::KIND_SORTED_PUSH, 16'hFFFF, 8'hFF, 1'b1, '{1'b1, 16'h1234, 8'hAB, 5'd2, 1'b0}},
      '{sis_pkg::KIND_SORTED_PUSH, 16'h0000, 8'h00, 1'b1, '{1'b1, 16'h0000, 8'h00, 5'd3, 1'b0}},
      '{sis_pkg::KIND_SORTED_PUSH, 16'h1234, 8'h55, 1'b0, '0},
      // plain push ignores order
      '{sis_pkg::KIND_PLAIN_PUSH,  16'h8000, 8'h80, 1'b1, '{1'b1, 16'h8000, 8'h80, 5'd5, 1'b0}},
      '{sis_pkg::KIND_POP,         16'h0000, 8'h00, 1'b0, '0},
      '{KIND_NOP,                  16'h5A5A, 8'hA5, 1'b0, '0},
      // fill up to full, with duplicates of stored keys
      '{sis_pkg::KIND_SORTED_PUSH, 16'h0001, 8'h01, 1'b0, '0},
      '{sis_pkg::KIND_SORTED_PUSH, 16'h7FFF, 8'h02, 1'b0, '0},
      '{sis_pkg::KIND_SORTED_PUSH, 16'h1234, 8'h04, 1'b0, '0},
      '{sis_pkg::KIND_SORTED_PUSH, 16'hFFFE, 8'h08, 1'b0, '0},
      '{sis_pkg::KIND_SORTED_PUSH, 16'h0002, 8'h10, 1'b0, '0},
      '{sis_pkg::KIND_PLAIN_PUSH,  16'h4000, 8'h20, 1'b0, '0},
      '{sis_pkg::KIND_SORTED_PUSH, 16'hFFFF, 8'h40, 1'b0, '0},
      '{sis_pkg::KIND_SORTED_PUSH, 16'h0100, 8'h80, 1'b0, '0},
      '{sis_pkg::KIND_SORTED_PUSH, 16'hC000, 8'hFE, 1'b0, '0},
      '{sis_pkg::KIND_SORTED_PUSH, 16'h0000, 8'h7F, 1'b0, '0},
      '{sis_pkg::KIND_SORTED_PUSH, 16'h2000, 8'h3C, 1'b0, '0},
      '{sis_pkg::KIND_SORTED_PUSH, 16'h9000, 8'hC3, 1'b0, '0},
      // push into the full stack
      '{sis_pkg::KIND_SORTED_PUSH, 16'h0800, 8'h11, 1'b0, '0},
      '{sis_pkg::KIND_PLAIN_PUSH,  16'h0800, 8'h22, 1'b0, '0}
   };

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [sis_pkg::KIND_BITS-1:0]     req_kind = '0;
   logic [sis_pkg::TIME_BITS-1:0]     req_start_time = '0;
   logic [sis_pkg::TAG_PORT_BITS-1:0] req_payload_tag = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic                              rsp_top_valid;
   logic [sis_pkg::TIME_BITS-1:0]     rsp_top_time;
   logic [sis_pkg::TAG_PORT_BITS-1:0] rsp_top_tag;
   logic [sis_pkg::CNT_BITS-1:0]      rsp_entry_count;
   logic                              rsp_overflow;

   // Shadow copy of the cells, top at index 0, and expected results in order.
   sis_pkg::entry_type shadow_cells [sis_pkg::DEPTH];
   int                 shadow_fill;
   stack_status_type   expected_tops [$];
   int                 fail_count = 0;
   bit                 quiet = 1'b0;

   sorted_insert_stack u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_kind        (req_kind),
      .req_start_time  (req_start_time),
      .req_payload_tag (req_payload_tag),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_top_valid   (rsp_top_valid),
      .rsp_top_time    (rsp_top_time),
      .rsp_top_tag     (rsp_top_tag),
      .rsp_entry_count (rsp_entry_count),
      .rsp_overflow    (rsp_overflow)
   );

   always #4 clock = ~clock;

   // Apply one item to the shadow stack and return the status it reports.
   function automatic stack_status_type predict_stack_op(
      logic [sis_pkg::KIND_BITS-1:0]     kind,
      logic [sis_pkg::TIME_BITS-1:0]     key,
      logic [sis_pkg::TAG_PORT_BITS-1:0] tag
   );
      stack_status_type s;
      int               pos;
      s = '0;
      if (kind == sis_pkg::KIND_SORTED_PUSH || kind == sis_pkg::KIND_PLAIN_PUSH) begin
         if (shadow_fill >= sis_pkg::DEPTH) begin
            s.overflow = 1'b1;
         end else begin
            pos = 0;
            if (kind == sis_pkg::KIND_SORTED_PUSH) begin
               while (pos < shadow_fill && shadow_cells[pos].start_time < key) pos++;
            end
            for (int i = shadow_fill; i > pos; i--) shadow_cells[i] = shadow_cells[i-1];
            shadow_cells[pos].valid      = 1'b1;
            shadow_cells[pos].start_time = key;
            shadow_cells[pos].tag        = tag[sis_pkg::TAG_BITS-1:0];
            shadow_fill++;
         end
      end else if (kind == sis_pkg::KIND_POP && shadow_fill > 0) begin
         for (int i = 0; i + 1 < shadow_fill; i++) shadow_cells[i] = shadow_cells[i+1];
         shadow_cells[shadow_fill-1] = sis_pkg::EMPTY_ENTRY;
         shadow_fill--;
      end
      if (shadow_fill > 0) begin
         s.top_valid = 1'b1;
         s.top_time  = shadow_cells[0].start_time;
         s.top_tag   = sis_pkg::TAG_PORT_BITS'(shadow_cells[0].tag);
      end
      s.entry_count = sis_pkg::CNT_BITS'(shadow_fill);
      return s;
   endfunction

   // Offer one item after a random gap, hold it until taken, then queue its status.
   task automatic send_item(logic [sis_pkg::KIND_BITS-1:0] kind,
                            logic [sis_pkg::TIME_BITS-1:0] key,
                            logic [sis_pkg::TAG_PORT_BITS-1:0] tag, logic has_exp,
                            stack_status_type typed_exp);
      stack_status_type s;
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_kind        <= kind;
      req_start_time  <= key;
      req_payload_tag <= tag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      s = predict_stack_op(kind, key, tag);
      expected_tops.push_back(has_exp ? typed_exp : s);
   endtask

   // Throttle the result side.
   always @(posedge clock) begin
      rsp_stall <= quiet ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
   end

   // Compare each taken result with the oldest expectation.
   always @(posedge clock) begin
      stack_status_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_tops.size() == 0) begin
            $error("result item with no expectation pending");
            fail_count++;
         end else begin
            e = expected_tops.pop_front();
            if (rsp_top_valid !== e.top_valid) begin
               $error("top_valid: expected %0d, got %0d", e.top_valid, rsp_top_valid);
               fail_count++;
            end
            if (rsp_top_time !== e.top_time) begin
               $error("top_time: expected %0h, got %0h", e.top_time, rsp_top_time);
               fail_count++;
            end
            if (rsp_top_tag !== e.top_tag) begin
               $error("top_tag: expected %0h, got %0h", e.top_tag, rsp_top_tag);
               fail_count++;
            end
            if (rsp_entry_count !== e.entry_count) begin
               $error("entry_count: expected %0d, got %0d", e.entry_count, rsp_entry_count);
               fail_count++;
            end
            if (rsp_overflow !== e.overflow) begin
               $error("overflow: expected %0d, got %0d", e.overflow, rsp_overflow);
               fail_count++;
            end
         end
      end
   end

   // Stimulus: reset, directed table, then random items that fill and drain.
   initial begin
      logic [sis_pkg::KIND_BITS-1:0]     kind;
      logic [sis_pkg::TIME_BITS-1:0]     key;
      logic [sis_pkg::TAG_PORT_BITS-1:0] tag;
      int                                push_pct;
      int                                r;
      int                                drain_cycles;
      for (int i = 0; i < sis_pkg::DEPTH; i++) shadow_cells[i] = sis_pkg::EMPTY_ENTRY;
      shadow_fill = 0;
      push_pct    = 50;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_item(DIRECTED[i].kind, DIRECTED[i].key, DIRECTED[i].tag,
                   DIRECTED[i].has_exp, DIRECTED[i].exp);
      end

      for (int i = 0; i < N_RANDOM; i++) begin
         // drift the push share so the stack swings between full and empty
         if (i % 60 == 0) push_pct = $urandom_range(10, 90);
         quiet = (i >= QUIET_FIRST && i < QUIET_LAST);
         r = $urandom_range(99);
         if (r < 3)
            kind = KIND_NOP;
         else if (r - 3 < push_pct)
            kind = ($urandom_range(3) == 0) ? sis_pkg::KIND_PLAIN_PUSH
                                            : sis_pkg::KIND_SORTED_PUSH;
         else
            kind = sis_pkg::KIND_POP;
         // crowd keys together often so equal keys meet in the stack
         case ($urandom_range(3))
            0: key = 16'h1000 + 16'($urandom_range(3));
            1: key = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            default: key = 16'($urandom_range(16'hFFFF));
         endcase
         tag = 8'($urandom_range(255));
         send_item(kind, key, tag, 1'b0, '0);
      end
      quiet = 1'b0;
      req_valid <= 1'b0;

      // wait for the remaining results, then a few cycles for strays
      drain_cycles = 0;
      while (expected_tops.size() != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (8) @(posedge clock);
      if (expected_tops.size() != 0) begin
         $error("%0d expected result items never arrived", expected_tops.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Hard stop if the handshakes hang.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
